FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the estimator and serial unit modules.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/sae_pkg.sv
// ---------------------------------------------------------------------------
// sae_pkg: swing axis angle estimator shared definitions
// Widths, the CORDIC arctangent table and the serial unit command types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sae_pkg;

  localparam int FRACTION_BITS   = 4;
  localparam int PAIR_COUNT_BITS = 16;
  localparam int SUM_BITS        = 24;
  localparam int SQSUM_BITS      = 32;
  localparam int WIDE_BITS       = 48;
  localparam int OPB_BITS        = 24;
  localparam int CORDIC_STEPS    = 24;
  localparam int ANGLE_FRAC      = 20;
  localparam int CORDIC_BITS     = 43;
  localparam int ZACC_BITS       = 29;

  localparam logic [PAIR_COUNT_BITS-1:0] PAIR_MAX = '1;
  localparam logic [15:0] THRESHOLD_RESET = 16'(100 << FRACTION_BITS);

  // atan(2^-i) in degrees, Q20
  localparam logic [26:0] ATAN_DEG_Q20 [CORDIC_STEPS] = '{
    27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121,
    27'd3750058,  27'd1876857,  27'd938658,   27'd469357,
    27'd234682,   27'd117342,   27'd58671,    27'd29335,
    27'd14668,    27'd7334,     27'd3667,     27'd1833,
    27'd917,      27'd458,      27'd229,      27'd115,
    27'd57,       27'd29,       27'd14,       27'd7
  };

  // serial unit operations
  typedef logic [1:0] op_t;
  localparam op_t OP_MUL  = 2'd0;
  localparam op_t OP_DIV  = 2'd1;
  localparam op_t OP_SQRT = 2'd2;

  typedef struct packed {
    logic start;
    op_t  op;
  } unit_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/swing_axis_angle_estimator.sv
// ---------------------------------------------------------------------------
// swing_axis_angle_estimator: mean swing axis angle from radius peaks
// Finds radius peaks, pairs them, sums pair angles and their squares, and on
// the last sample reports the mean and spread with a bit-serial unit.
// ---------------------------------------------------------------------------
//  channel  handshake                 payload
//  cfg      cfg_write_en              cfg_write_data (radius threshold)
//  in       in_valid / in_ready       x_offset, y_offset, radius, last_sample
//  out      out_valid / out_ready     mean_angle, angle_error, pair_count,
//                                     no_pairs, count_overflow
//
//  A sample that closes no pair leaves the input ready; one that closes a pair
//  holds the input off for the 24-step CORDIC loop.
//  The last sample then runs the serial unit: two 24-bit multiplies, three
//  48-step divides and a 24-step square root.
//  Reset is synchronous; the threshold resets to 100 pixels.
//  A waiting result does not block input until the next result is due.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module swing_axis_angle_estimator (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write_en,
  input  wire logic [15:0]        cfg_write_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] x_offset,
  input  wire logic signed [15:0] y_offset,
  input  wire logic [15:0]        radius,
  input  wire logic               last_sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              mean_angle,
  output logic [7:0]              angle_error,
  output logic [15:0]             pair_count,
  output logic                    no_pairs,
  output logic                    count_overflow
);
  import sae_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CORD = 4'd1;
  localparam logic [3:0] S_STAT = 4'd2;
  localparam logic [3:0] S_MUL1 = 4'd3;
  localparam logic [3:0] S_MUL2 = 4'd4;
  localparam logic [3:0] S_DIV1 = 4'd5;
  localparam logic [3:0] S_DIVM = 4'd6;
  localparam logic [3:0] S_SQRT = 4'd7;
  localparam logic [3:0] S_DIVE = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]                 state;
  logic [15:0]                threshold;
  logic [15:0]                older_radius;
  logic [15:0]                candidate_radius;
  logic signed [15:0]         candidate_x;
  logic signed [15:0]         candidate_y;
  logic [1:0]                 fill_count;
  logic                       pair_open;
  logic signed [15:0]         first_peak_x;
  logic signed [15:0]         first_peak_y;
  logic [PAIR_COUNT_BITS-1:0] pairs_seen;
  logic [SUM_BITS-1:0]        angle_sum;
  logic [SQSUM_BITS-1:0]      angle_square_sum;
  logic                       saturated_flag;
  logic                       last_pend;
  logic [WIDE_BITS-1:0]       wide;
  logic [7:0]                 res_mean;
  logic [7:0]                 res_err;

  logic                       in_take;
  logic                       emit;
  logic                       peak;
  logic                       cord_start;
  logic signed [16:0]         dx;
  logic signed [16:0]         dy;
  logic                       cord_done;
  logic [7:0]                 cord_angle;
  logic [15:0]                angle_sq;
  unit_cmd_t                  cmd;
  unit_stat_t                 stat;
  logic [WIDE_BITS-1:0]       opa_in;
  logic [OPB_BITS-1:0]        opb_in;
  logic [WIDE_BITS-1:0]       result;

  // handshakes, peak test on the pending candidate and pair deltas
  assign in_ready   = (state == S_IDLE);
  assign in_take    = in_valid && in_ready;
  assign emit       = (state == S_OUT) && (!out_valid || out_ready);
  assign peak       = (fill_count == 2'd2) && (candidate_radius > older_radius) &&
                      (candidate_radius >= radius) && (candidate_radius > threshold);
  assign cord_start = in_take && peak && pair_open;
  assign dx         = {candidate_x[15], candidate_x} - {first_peak_x[15], first_peak_x};
  assign dy         = {candidate_y[15], candidate_y} - {first_peak_y[15], first_peak_y};
  assign angle_sq   = {8'b0, cord_angle} * {8'b0, cord_angle};

  sae_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .dx    (dx),
    .dy    (dy),
    .done  (cord_done),
    .angle (cord_angle)
  );

  // issue serial unit operations in sequence
  always_comb begin
    cmd.start = 1'b0;
    cmd.op    = OP_MUL;
    opa_in    = '0;
    opb_in    = OPB_BITS'(pairs_seen);
    case (state)
      S_STAT: begin
        if (pairs_seen != '0) begin
          cmd.start = 1'b1;
          opa_in    = WIDE_BITS'(angle_square_sum);
        end
      end
      S_MUL1: begin
        cmd.start = stat.done;
        opa_in    = WIDE_BITS'(angle_sum);
        opb_in    = OPB_BITS'(angle_sum);
      end
      S_MUL2: begin
        cmd.start = stat.done;
        cmd.op    = OP_DIV;
        opa_in    = wide - result;
      end
      S_DIV1: begin
        cmd.start = stat.done;
        cmd.op    = OP_DIV;
        opa_in    = WIDE_BITS'(angle_sum);
      end
      S_DIVM: begin
        cmd.start = stat.done;
        cmd.op    = OP_SQRT;
        opa_in    = wide;
      end
      S_SQRT: begin
        cmd.start = stat.done;
        cmd.op    = OP_DIV;
        opa_in    = WIDE_BITS'(result[23:0]);
      end
      default: begin
        cmd.start = 1'b0;
      end
    endcase
  end

  sae_serial u_serial (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .opa_in (opa_in),
    .opb_in (opb_in),
    .stat   (stat),
    .result (result)
  );

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_write_en) begin
      threshold <= cfg_write_data;
    end
  end

  // hold the result word until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer, run state and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      older_radius     <= '0;
      candidate_radius <= '0;
      candidate_x      <= '0;
      candidate_y      <= '0;
      fill_count       <= '0;
      pair_open        <= 1'b0;
      first_peak_x     <= '0;
      first_peak_y     <= '0;
      pairs_seen       <= '0;
      angle_sum        <= '0;
      angle_square_sum <= '0;
      saturated_flag   <= 1'b0;
      last_pend        <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_take) begin
            if (peak) begin
              if (!pair_open) begin
                first_peak_x <= candidate_x;
                first_peak_y <= candidate_y;
              end
              pair_open <= !pair_open;
            end
            older_radius     <= candidate_radius;
            candidate_radius <= radius;
            candidate_x      <= x_offset;
            candidate_y      <= y_offset;
            if (fill_count != 2'd2) fill_count <= fill_count + 2'd1;
            last_pend <= last_sample;
            if (peak && pair_open) state <= S_CORD;
            else if (last_sample)  state <= S_STAT;
          end
        end
        S_CORD: begin
          if (cord_done) begin
            if (pairs_seen >= PAIR_MAX) begin
              saturated_flag <= 1'b1;
            end else begin
              pairs_seen       <= pairs_seen + 1'b1;
              angle_sum        <= angle_sum + SUM_BITS'(cord_angle);
              angle_square_sum <= angle_square_sum + SQSUM_BITS'(angle_sq);
            end
            state <= last_pend ? S_STAT : S_IDLE;
          end
        end
        S_STAT: begin
          if (pairs_seen == '0) begin
            res_mean <= '0;
            res_err  <= '0;
            state    <= S_OUT;
          end else begin
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          if (stat.done) begin
            wide  <= result;
            state <= S_MUL2;
          end
        end
        S_MUL2: if (stat.done) state <= S_DIV1;
        S_DIV1: begin
          if (stat.done) begin
            wide  <= result;
            state <= S_DIVM;
          end
        end
        S_DIVM: begin
          if (stat.done) begin
            res_mean <= result[7:0];
            state    <= S_SQRT;
          end
        end
        S_SQRT: if (stat.done) state <= S_DIVE;
        S_DIVE: begin
          if (stat.done) begin
            res_err <= result[7:0];
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (emit) begin
            mean_angle       <= res_mean;
            angle_error      <= res_err;
            pair_count       <= 16'(pairs_seen);
            no_pairs         <= (pairs_seen == '0);
            count_overflow   <= saturated_flag;
            older_radius     <= '0;
            candidate_radius <= '0;
            candidate_x      <= '0;
            candidate_y      <= '0;
            fill_count       <= '0;
            pair_open        <= 1'b0;
            first_peak_x     <= '0;
            first_peak_y     <= '0;
            pairs_seen       <= '0;
            angle_sum        <= '0;
            angle_square_sum <= '0;
            saturated_flag   <= 1'b0;
            last_pend        <= 1'b0;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NXT(a_cord_enters, cord_start, state == S_CORD)
  `ASSERT_IMP(a_no_pairs_zero, out_valid && no_pairs,
              mean_angle == 8'd0 && angle_error == 8'd0 && pair_count == 16'd0)
  `ASSERT_IMP(a_mean_range, out_valid, mean_angle < 8'd180 && angle_error < 8'd180)
  `ASSERT_IMP(a_fill_range, in_take, fill_count != 2'd3)

endmodule

`default_nettype wire

FILE: hw/rtl/sae_serial.sv
// ---------------------------------------------------------------------------
// sae_serial: bit-serial multiply, divide and square root unit
// One result bit (or one multiplier bit) per cycle through shift registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sae_serial (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire sae_pkg::unit_cmd_t        cmd,
  input  wire logic [sae_pkg::WIDE_BITS-1:0] opa_in,
  input  wire logic [sae_pkg::OPB_BITS-1:0]  opb_in,
  output sae_pkg::unit_stat_t            stat,
  output logic [sae_pkg::WIDE_BITS-1:0]  result
);
  import sae_pkg::*;

  logic                 busy;
  logic                 done;
  op_t                  op;
  logic [5:0]           cnt;
  logic [5:0]           last_cnt;
  logic [WIDE_BITS-1:0] opa;
  logic [WIDE_BITS-1:0] acc;
  logic [OPB_BITS-1:0]  opb;
  logic [26:0]          rem;

  logic [WIDE_BITS-1:0] acc_mul;
  logic [16:0]          div_sh;
  logic                 div_ge;
  logic [16:0]          div_rem;
  logic [26:0]          sq_sh;
  logic [26:0]          sq_trial;
  logic                 sq_ge;

  // iteration count per operation
  assign last_cnt = (op == OP_DIV) ? 6'd47 : 6'd23;

  // one step of each operation
  always_comb begin
    acc_mul  = opb[0] ? acc + opa : acc;
    div_sh   = {rem[15:0], opa[WIDE_BITS-1]};
    div_ge   = div_sh >= {1'b0, opb[15:0]};
    div_rem  = div_ge ? div_sh - {1'b0, opb[15:0]} : div_sh;
    sq_sh    = {rem[24:0], opa[WIDE_BITS-1:WIDE_BITS-2]};
    sq_trial = {1'b0, acc[23:0], 2'b01};
    sq_ge    = sq_sh >= sq_trial;
  end

  // advance the active operation
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        op   <= cmd.op;
        opa  <= opa_in;
        opb  <= opb_in;
        acc  <= '0;
        rem  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        case (op)
          OP_MUL: begin
            acc <= acc_mul;
            opa <= {opa[WIDE_BITS-2:0], 1'b0};
            opb <= {1'b0, opb[OPB_BITS-1:1]};
          end
          OP_DIV: begin
            rem <= {11'b0, div_rem[15:0]};
            opa <= {opa[WIDE_BITS-2:0], div_ge};
          end
          OP_SQRT: begin
            rem <= sq_ge ? sq_sh - sq_trial : sq_sh;
            acc <= {acc[WIDE_BITS-2:0], sq_ge};
            opa <= {opa[WIDE_BITS-3:0], 2'b00};
          end
          default: begin
            rem <= rem;
          end
        endcase
        cnt <= cnt + 6'd1;
        if (cnt == last_cnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = (op == OP_DIV) ? opa : acc;

  `ASSERT_IMP(a_start_when_free, cmd.start, !busy)
  `ASSERT_NXT(a_start_runs, cmd.start, busy && !done)
  `ASSERT_IMP(a_done_not_busy, done, !busy)

endmodule

`default_nettype wire

FILE: hw/rtl/sae_cordic.sv
// ---------------------------------------------------------------------------
// sae_cordic: iterative arctangent of a peak pair
// Vectoring CORDIC, one rotation per cycle, result folded to 0..179 degrees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sae_cordic (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [16:0] dx,
  input  wire logic signed [16:0] dy,
  output logic                    done,
  output logic [7:0]              angle
);
  import sae_pkg::*;

  logic                          running;
  logic [4:0]                    step;
  logic signed [CORDIC_BITS-1:0] xr;
  logic signed [CORDIC_BITS-1:0] yr;
  logic signed [ZACC_BITS-1:0]   zr;
  logic                          sp_zero;
  logic                          sp_90;
  logic                          sp_45;
  logic                          neg;

  logic [16:0]                   ax;
  logic [16:0]                   ay;
  logic signed [CORDIC_BITS-1:0] xs;
  logic signed [CORDIC_BITS-1:0] ys;
  logic signed [ZACC_BITS-1:0]   ang;
  logic [8:0]                    deg;
  logic [7:0]                    base;

  // shift toward zero by magnitude
  function automatic logic signed [CORDIC_BITS-1:0] shr_mag(
    input logic signed [CORDIC_BITS-1:0] v,
    input logic [4:0]                    s
  );
    logic signed [CORDIC_BITS-1:0] m;
    begin
      m = (v < 0) ? -v : v;
      m = m >>> s;
      shr_mag = (v < 0) ? -m : m;
    end
  endfunction

  always_comb begin
    ax  = dx[16] ? 17'(-dx) : 17'(dx);
    ay  = dy[16] ? 17'(-dy) : 17'(dy);
    xs  = shr_mag(xr, step);
    ys  = shr_mag(yr, step);
    ang = signed'({2'b00, ATAN_DEG_Q20[step]});
  end

  // load and rotate
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
        xr      <= signed'({2'b00, ax, 24'b0});
        yr      <= signed'({2'b00, ay, 24'b0});
        zr      <= '0;
        sp_zero <= (ay == 17'd0);
        sp_90   <= (ax == 17'd0) && (ay != 17'd0);
        sp_45   <= (ax == ay) && (ax != 17'd0);
        neg     <= dx[16] ^ dy[16];
      end else if (running) begin
        if (yr > 0) begin
          xr <= xr + ys;
          yr <= yr - xs;
          zr <= zr + ang;
        end else begin
          xr <= xr - ys;
          yr <= yr + xs;
          zr <= zr - ang;
        end
        if (step == 5'(CORDIC_STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          step <= step + 5'd1;
        end
      end
    end
  end

  // truncate, clamp, handle exact cases and fold
  always_comb begin
    deg = zr[ZACC_BITS-1] ? 9'd0 : zr[ZACC_BITS-1:ANGLE_FRAC];
    if (deg > 9'd89) deg = 9'd89;
    if (sp_zero)     base = 8'd0;
    else if (sp_90)  base = 8'd90;
    else if (sp_45)  base = 8'd45;
    else             base = deg[7:0];
    angle = (neg && base != 8'd0) ? 8'd180 - base : base;
  end

endmodule

`default_nettype wire

FILE: tb/swing_checker.sv
// ---------------------------------------------------------------------------
// swing_checker: run summary predictor and comparator
// Watches the threshold port and the sample and summary channels. It models
// peak finding, pairing, the CORDIC pair angle and the mean/spread math, and
// compares each summary word with the oldest predicted one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module swing_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [15:0]        cfg_write_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] x_offset,
  input  logic signed [15:0] y_offset,
  input  logic [15:0]        radius,
  input  logic               last_sample,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [7:0]         mean_angle,
  input  logic [7:0]         angle_error,
  input  logic [15:0]        pair_count,
  input  logic               no_pairs,
  input  logic               count_overflow,
  output int                 fail_count,
  output int                 pending_summaries
);
  import sae_pkg::*;

  typedef struct {
    logic [7:0]  mean;
    logic [7:0]  err;
    logic [15:0] pairs;
    logic        empty;
    logic        ovf;
  } summary_t;

  summary_t summary_q[$];

  logic [15:0] thresh;
  logic [15:0] prev_r, cand_r;
  int          cand_x, cand_y, first_x, first_y;
  int          fill;
  bit          half_pair;
  longint      n_pairs, a_sum, a_sq_sum;
  bit          sat;

  assign pending_summaries = summary_q.size();

  // Shift toward zero by magnitude.
  function automatic longint mag_shift(longint v, int s);
    return (v >= 0) ? (v >>> s) : -((-v) >>> s);
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic int axis_angle(int dx, int dy);
    longint ax, ay, cx, cy, cz, xs, ys, deg;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax == 0 && ay == 0) return 0;
    if (ax == 0) return 90;
    if (ay == 0) return 0;
    if (ax == ay) begin
      deg = 45;
    end else begin
      cx = ax <<< 24;
      cy = ay <<< 24;
      cz = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = mag_shift(cx, i);
        ys = mag_shift(cy, i);
        if (cy > 0) begin
          cx += ys; cy -= xs; cz += longint'(ATAN_DEG_Q20[i]);
        end else begin
          cx -= ys; cy += xs; cz -= longint'(ATAN_DEG_Q20[i]);
        end
      end
      deg = (cz < 0) ? 0 : (cz >>> ANGLE_FRAC);
      if (deg > 89) deg = 89;
    end
    if (((dx < 0) != (dy < 0)) && deg > 0) deg = 180 - deg;
    return int'(deg);
  endfunction

  task automatic clear_run();
    prev_r = 0; cand_r = 0; cand_x = 0; cand_y = 0; fill = 0;
    half_pair = 0; first_x = 0; first_y = 0;
    n_pairs = 0; a_sum = 0; a_sq_sum = 0; sat = 0;
  endtask

  task automatic add_peak(int px, int py);
    longint a;
    if (!half_pair) begin
      first_x = px; first_y = py; half_pair = 1;
      return;
    end
    half_pair = 0;
    a = axis_angle(px - first_x, py - first_y);
    if (n_pairs >= longint'(PAIR_MAX)) begin
      sat = 1;
      return;
    end
    n_pairs++;
    a_sum += a;
    a_sq_sum += a * a;
  endtask

  task automatic take_sample(int x, int y, logic [15:0] r, logic fin);
    summary_t s;
    longint v;
    if (fill == 2 && cand_r > prev_r && cand_r >= r && cand_r > thresh)
      add_peak(cand_x, cand_y);
    prev_r = cand_r; cand_r = r; cand_x = x; cand_y = y;
    if (fill < 2) fill++;
    if (!fin) return;
    s.mean = 0; s.err = 0;
    if (n_pairs != 0) begin
      v = n_pairs * a_sq_sum - a_sum * a_sum;
      s.mean = 8'(a_sum / n_pairs);
      s.err = 8'(int_sqrt(v / n_pairs) / n_pairs);
    end
    s.pairs = 16'(n_pairs);
    s.empty = (n_pairs == 0);
    s.ovf = sat;
    summary_q.insert(summary_q.size(), s);
    clear_run();
  endtask

  // Predict on accepted samples, compare on accepted summary words.
  always @(posedge clk) begin
    summary_t e;
    if (rst) begin
      thresh <= THRESHOLD_RESET;
      clear_run();
      summary_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_write_en) thresh <= cfg_write_data;
      if (in_valid && in_ready)
        take_sample(x_offset, y_offset, radius, last_sample);
      if (out_valid && out_ready) begin
        if (summary_q.size() == 0) begin
          $error("unexpected summary word");
          fail_count <= fail_count + 1;
        end else begin
          e = summary_q.pop_front();
          if (mean_angle !== e.mean || angle_error !== e.err ||
              pair_count !== e.pairs || no_pairs !== e.empty ||
              count_overflow !== e.ovf) begin
            if (mean_angle !== e.mean)
              $error("mean_angle exp %0d got %0d", e.mean, mean_angle);
            if (angle_error !== e.err)
              $error("angle_error exp %0d got %0d", e.err, angle_error);
            if (pair_count !== e.pairs)
              $error("pair_count exp %0d got %0d", e.pairs, pair_count);
            if (no_pairs !== e.empty)
              $error("no_pairs exp %0d got %0d", e.empty, no_pairs);
            if (count_overflow !== e.ovf)
              $error("count_overflow exp %0d got %0d", e.ovf, count_overflow);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: swing axis angle estimator testbench
// Drives directed and random sample runs with random idle bursts on both
// channels, changes the radius threshold between runs, and reports the
// verdict from the checker's failure count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import sae_pkg::*;

  logic               clk, rst;
  logic               cfg_write_en;
  logic [15:0]        cfg_write_data;
  logic               in_valid, in_ready;
  logic signed [15:0] x_offset, y_offset;
  logic [15:0]        radius;
  logic               last_sample;
  logic               out_valid, out_ready;
  logic [7:0]         mean_angle, angle_error;
  logic [15:0]        pair_count;
  logic               no_pairs, count_overflow;
  int                 fail_count, pending_summaries;
  int                 sent;
  bit                 calm;
  longint             cycles;

  swing_axis_angle_estimator dut (.*);

  swing_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Abort a hung run.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Summary side: random stall bursts, none once calm.
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      out_ready <= 1;
    end
  end

  // Present one sample word and hold until accepted.
  task automatic send_word(logic signed [15:0] x, logic signed [15:0] y,
                           logic [15:0] r, logic fin);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1;
    x_offset <= x; y_offset <= y; radius <= r; last_sample <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // Drop the input, wait for all summaries, drain, then write the threshold.
  task automatic set_threshold(logic [15:0] v);
    in_valid <= 0;
    while (pending_summaries != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    cfg_write_en <= 1;
    cfg_write_data <= v;
    @(negedge clk);
    cfg_write_en <= 0;
  endtask

  // Random run: alternating rise/fall radius so peaks pair up often, or random radii when noisy.
  task automatic random_run(int len, bit noisy);
    logic [15:0] r;
    for (int i = 0; i < len; i++) begin
      if (noisy) r = 16'($urandom);
      else r = (i % 3 == 1) ? 16'($urandom_range(2000, 65535))
                            : 16'($urandom_range(0, 1999));
      send_word(16'($urandom), 16'($urandom), r, i == len - 1);
    end
  endtask

  initial begin
    calm = 0; sent = 0;
    rst = 1; cfg_write_en = 0; cfg_write_data = 0;
    in_valid = 0; x_offset = 0; y_offset = 0; radius = 0; last_sample = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Lone last sample: no pairs.
    send_word(0, 0, 16'hFFFF, 1);
    // Two peaks along an axis at 45 degrees, then a horizontal pair and a lone peak.
    send_word(0, 0, 0, 0);
    send_word(16'sh7FFF, 16'sh7FFF, 16'hFFFF, 0);
    send_word(0, 0, 0, 0);
    send_word(-16'sh8000, -16'sh8000, 16'hFFFF, 0);
    send_word(0, 0, 16'hFFFF, 0);
    send_word(0, 0, 16'hFFFF, 0);
    send_word(100, 7, 16'hFFFF, 0);
    send_word(5, 0, 2000, 0);
    send_word(5, 0, 16'hFFFF, 0);
    send_word(-30, 40, 3000, 0);
    send_word(0, 0, 0, 0);
    send_word(0, 0, 3000, 0);
    send_word(1, 1, 10, 0);
    send_word(40, -30, 3000, 0);
    send_word(2, 2, 3000, 1);
    // Coincident peaks and a lone trailing peak.
    send_word(0, 0, 0, 0);
    send_word(9, 9, 5000, 0);
    send_word(0, 0, 0, 0);
    send_word(9, 9, 5000, 0);
    send_word(0, 0, 0, 0);
    send_word(3, -3, 5000, 0);
    send_word(0, 0, 0, 1);

    set_threshold(16'hFFFF);
    random_run(20, 0);
    set_threshold(0);
    random_run(30, 0);

    while (sent < 900) begin
      set_threshold(16'($urandom_range(0, 4000)));
      repeat (4) random_run($urandom_range(2, 40), $urandom_range(0, 4) == 0);
    end
    set_threshold(THRESHOLD_RESET);
    calm = 1;
    random_run(60, 0);
    in_valid <= 0;

    while (pending_summaries != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: swing_axis_angle_estimator.f
+incdir+hw/rtl
hw/rtl/sae_pkg.sv
hw/rtl/sae_serial.sv
hw/rtl/sae_cordic.sv
hw/rtl/swing_axis_angle_estimator.sv
tb/swing_checker.sv
tb/tb_top.sv
